FILE: hw/rtl/http_response_stream_parser_macros.svh
// Assertion macros for the HTTP response stream parser.
// No dependencies; included by the modules that carry assertions.
`ifndef HTTP_RESPONSE_STREAM_PARSER_MACROS_SVH
`define HTTP_RESPONSE_STREAM_PARSER_MACROS_SVH
`ifndef ASSERT_OFF
`define HRSP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HRSP_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HRSP_ASSERT(label, clk, rst_n, prop, msg)
`define HRSP_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

FILE: hw/rtl/hrsp_pkg.sv
// Shared types and constants for the HTTP response stream parser.
// No dependencies.
package hrsp_pkg;
    localparam int          LENGTH_BITS_DEF  = 32;
    localparam logic [15:0] MAX_LINE_RESET   = 16'd8192;
    localparam logic [31:0] MAX_CHUNK_RESET  = 32'd67108864;
    localparam int          QUEUE_DEPTH      = 2;

    localparam logic [2:0] PH_STATUS  = 3'd0;
    localparam logic [2:0] PH_HEADERS = 3'd1;
    localparam logic [2:0] PH_FIXED   = 3'd2;
    localparam logic [2:0] PH_CHUNKED = 3'd3;
    localparam logic [2:0] PH_EOF     = 3'd4;
    localparam logic [2:0] PH_DONE    = 3'd5;
    localparam logic [2:0] PH_ERROR   = 3'd6;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_PARSE   = 3'd1;
    localparam logic [2:0] ERR_VERSION = 3'd2;
    localparam logic [2:0] ERR_HEADER  = 3'd3;
    localparam logic [2:0] ERR_CHUNK   = 3'd4;

    localparam logic CFG_MAX_LINE  = 1'b0;
    localparam logic CFG_MAX_CHUNK = 1'b1;

    typedef enum logic [3:0] {
        S_VER_OK, S_VER_BAD, S_CODE0, S_CODE, S_REASON, S_BAD, S_BADVER,
        H_NAME, H_LEAD, H_CL, H_CL_TAIL, H_TE, H_TE_TAIL, H_SKIP, H_BAD,
        C_LEAD
    } t_sub;
    // chunk sub phases share code space; kept in a separate enum
    typedef enum logic [2:0] {
        CK_LEAD, CK_HEX, CK_REST, CK_BAD, CK_DATA, CK_TRAIL
    } t_csub;

    // classified byte handed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       is_digit;
        logic       is_ws;
        logic       is_hex;
        logic [3:0] hex;
        logic [7:0] lower;
    } t_beat;

    function automatic t_beat classify(input logic [7:0] c);
        t_beat b;
        b.data     = c;
        b.is_digit = (c >= 8'h30 && c <= 8'h39);
        b.is_ws    = (c == 8'h20 || c == 8'h09);
        b.lower    = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
        b.is_hex   = b.is_digit || (b.lower >= 8'h61 && b.lower <= 8'h66);
        b.hex      = b.is_digit ? c[3:0] : b.lower[3:0] + 4'd9;
        return b;
    endfunction

    function automatic logic [7:0] ver_char(input logic [2:0] i);
        case (i)
            3'd0: return 8'h48; 3'd1: return 8'h54; 3'd2: return 8'h54;
            3'd3: return 8'h50; 3'd4: return 8'h2F; 3'd5: return 8'h31;
            3'd6: return 8'h2E;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] cl_char(input logic [3:0] i);
        case (i)
            4'd0: return "c"; 4'd1: return "o"; 4'd2: return "n"; 4'd3: return "t";
            4'd4: return "e"; 4'd5: return "n"; 4'd6: return "t"; 4'd7: return "-";
            4'd8: return "l"; 4'd9: return "e"; 4'd10: return "n"; 4'd11: return "g";
            4'd12: return "t"; 4'd13: return "h";
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] te_char_at(input logic [4:0] i);
        case (i)
            5'd0: return "t"; 5'd1: return "r"; 5'd2: return "a"; 5'd3: return "n";
            5'd4: return "s"; 5'd5: return "f"; 5'd6: return "e"; 5'd7: return "r";
            5'd8: return "-"; 5'd9: return "e"; 5'd10: return "n"; 5'd11: return "c";
            5'd12: return "o"; 5'd13: return "d"; 5'd14: return "i"; 5'd15: return "n";
            5'd16: return "g";
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] ck_char(input logic [2:0] i);
        case (i)
            3'd0: return "c"; 3'd1: return "h"; 3'd2: return "u"; 3'd3: return "n";
            3'd4: return "k"; 3'd5: return "e"; 3'd6: return "d";
            default: return 8'h00;
        endcase
    endfunction
endpackage

FILE: hw/rtl/hrsp_front.sv
// Front end: takes raw bytes, classifies them, and queues them for the back end.
// Depends on hrsp_pkg.
module hrsp_front
    import hrsp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_q_valid,
    output t_beat      o_q_beat,
    input  logic       i_q_pop
);
    t_beat       r_mem [QUEUE_DEPTH];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        push;

    assign o_stall   = (r_cnt == 2'(QUEUE_DEPTH));
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_beat  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= classify(i_in_byte);
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end
endmodule

FILE: hw/rtl/hrsp_back.sv
// Back end: parse state machine and registered result stage.
// Depends on hrsp_pkg and the assertion macro header.
`include "http_response_stream_parser_macros.svh"
module hrsp_back
    import hrsp_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_beat       i_q_beat,
    output logic        o_q_pop,
    input  logic [15:0] i_max_line,
    input  logic [31:0] i_max_chunk,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_body_valid,
    output logic [7:0]  o_body_data,
    output logic [2:0]  o_phase,
    output logic [9:0]  o_resp_code,
    output logic [2:0]  o_error_kind
);
    localparam int LB = LENGTH_BITS;
    localparam int WB = LB + 5;
    // chunk size compare width: wide enough for both the size and the limit
    localparam int CW = (LB + 4 > 32) ? LB + 4 : 32;

    logic [2:0]    r_phase, n_phase;
    logic [3:0]    r_sub, n_sub;
    logic [15:0]   r_cnt, n_cnt;
    logic          r_cr, n_cr;
    logic [9:0]    r_code, n_code;
    logic [4:0]    r_flags, n_flags;
    logic [LB-1:0] r_acc, n_acc;
    logic          r_chk, n_chk;
    logic          r_lseen, n_lseen;
    logic [LB-1:0] r_rem, n_rem;
    logic [1:0]    r_trail, n_trail;
    logic [2:0]    r_err, n_err;
    logic          r_ov, r_obv;
    logic [7:0]    r_obd;
    logic          bv;

    logic take;
    assign o_q_pop = take;
    assign take    = i_q_valid && (!r_ov || !i_stall);
    assign o_valid = r_ov;
    assign o_body_valid  = r_obv;
    assign o_body_data   = r_obd;
    assign o_phase       = r_phase;
    assign o_resp_code   = (r_phase == PH_STATUS) ? 10'd0 : r_code;
    assign o_error_kind  = (r_phase == PH_ERROR) ? r_err : ERR_NONE;

    localparam logic [4:0] F_CL = 5'd1, F_TE = 5'd2, F_LCL = 5'd4, F_LTE = 5'd8,
                           F_OVER = 5'd16;

    always_comb begin
        t_beat         b;
        logic [7:0]    c;
        logic          line;
        logic          cr_byte;
        logic          done;
        logic [15:0]   p;
        logic [13:0]   cv;
        logic [WB-1:0] wv;
        logic [LB+3:0] hv;
        n_phase = r_phase; n_sub = r_sub; n_cnt = r_cnt; n_cr = r_cr;
        n_code = r_code; n_flags = r_flags; n_acc = r_acc; n_chk = r_chk;
        n_lseen = r_lseen; n_rem = r_rem; n_trail = r_trail; n_err = r_err;
        bv = 1'b0;
        b = i_q_beat; c = b.data;
        line = 1'b0; cr_byte = 1'b0; done = 1'b0; p = r_cnt;
        cv = '0; wv = '0; hv = '0;
        case (r_phase)
            PH_STATUS, PH_HEADERS: line = 1'b1;
            PH_CHUNKED: begin
                if (r_sub == 4'(CK_DATA)) begin
                    bv = 1'b1;
                    n_rem = r_rem - 1'b1;
                    if (n_rem == '0) begin n_sub = 4'(CK_TRAIL); n_trail = 2'd2; end
                end else if (r_sub == 4'(CK_TRAIL)) begin
                    if (r_trail == 2'd2 && c == 8'h0D) n_trail = 2'd1;
                    else if (r_trail == 2'd1 && c == 8'h0A) begin
                        n_trail = 2'd0; n_sub = 4'(CK_LEAD); n_cnt = '0;
                        n_acc = '0; n_flags = '0;
                    end else begin
                        n_trail = 2'd0; n_phase = PH_ERROR; n_err = ERR_CHUNK;
                        n_cr = 1'b0;
                    end
                end else line = 1'b1;
            end
            PH_FIXED: begin
                bv = 1'b1;
                n_rem = r_rem - 1'b1;
                if (n_rem == '0) n_phase = PH_DONE;
            end
            PH_EOF: bv = 1'b1;
            default: ;
        endcase

        if (line) begin
            // a held CR not followed by LF becomes line content ahead of this byte
            if (r_cr) begin
                n_cr = 1'b0;
                if (c == 8'h0A) begin
                    done = 1'b1;
                    case (r_phase)
                        PH_STATUS: begin
                            if (r_sub == S_BADVER) begin
                                n_phase = PH_ERROR; n_err = ERR_VERSION; n_code = '0;
                            end else if ((r_sub != S_CODE && r_sub != S_REASON)
                                         || r_code < 10'd100 || r_code > 10'd599) begin
                                n_phase = PH_ERROR; n_err = ERR_PARSE; n_code = '0;
                            end else begin
                                n_phase = PH_HEADERS;
                                n_sub = H_NAME; n_cnt = '0; n_acc = '0;
                                n_flags = F_CL | F_TE;
                            end
                        end
                        PH_HEADERS: begin
                            if (r_sub == H_NAME && r_cnt == '0) begin
                                if (r_chk) n_phase = PH_CHUNKED;
                                else if (r_lseen)
                                    n_phase = (r_rem != '0) ? PH_FIXED : PH_DONE;
                                else n_phase = PH_EOF;
                                n_sub = (r_chk) ? 4'(CK_LEAD) : H_NAME;
                                n_cnt = '0; n_acc = '0; n_flags = F_CL | F_TE;
                            end else if (r_sub == H_NAME || r_sub == H_BAD) begin
                                n_phase = PH_ERROR; n_err = ERR_HEADER;
                            end else begin
                                if (r_sub == H_CL || r_sub == H_CL_TAIL) begin
                                    n_rem = r_acc; n_lseen = 1'b1;
                                end else if ((r_sub == H_TE && r_acc == LB'(7))
                                             || r_sub == H_TE_TAIL) begin
                                    n_chk = 1'b1;
                                end
                                n_sub = H_NAME; n_cnt = '0; n_acc = '0;
                                n_flags = F_CL | F_TE;
                            end
                        end
                        default: begin
                            if (r_sub == 4'(CK_LEAD) || r_sub == 4'(CK_BAD)
                                || (r_flags & F_OVER) != '0) begin
                                n_phase = PH_ERROR; n_err = ERR_CHUNK;
                            end else if (r_acc == '0) n_phase = PH_DONE;
                            else begin
                                n_rem = r_acc; n_sub = 4'(CK_DATA);
                            end
                        end
                    endcase
                end else begin
                    cr_byte = 1'b1;
                end
            end
            if (!done) begin
                // one or two content bytes: the stale CR, then this byte
                for (int k = 0; k < 2; k++) begin
                    t_beat cb;
                    logic  use_it;
                    cb = (k == 0) ? classify(8'h0D) : b;
                    use_it = (k == 0) ? cr_byte : (c != 8'h0D);
                    if (k == 1 && c == 8'h0D && n_phase != PH_ERROR) n_cr = 1'b1;
                    if (use_it && n_phase != PH_ERROR) begin
                        p = n_cnt;
                        if (n_phase == PH_CHUNKED) begin
                            case (n_sub)
                                4'(CK_LEAD): if (cb.data != 8'h20) begin
                                    n_sub = cb.is_hex ? 4'(CK_HEX) : 4'(CK_BAD);
                                    if (cb.is_hex) begin
                                        n_acc = LB'(cb.hex);
                                        if ({28'd0, cb.hex} > i_max_chunk)
                                            n_flags = n_flags | F_OVER;
                                    end
                                end
                                4'(CK_HEX): begin
                                    if (!cb.is_hex) n_sub = 4'(CK_REST);
                                    else if ((n_flags & F_OVER) == '0) begin
                                        hv = {n_acc, cb.hex};
                                        if (hv[LB+3:LB] != '0
                                            || CW'(hv) > CW'(i_max_chunk))
                                            n_flags = n_flags | F_OVER;
                                        else n_acc = hv[LB-1:0];
                                    end
                                end
                                default: ;
                            endcase
                        end else if (p >= i_max_line) begin
                            if (n_phase == PH_STATUS) n_code = '0;
                            n_phase = PH_ERROR; n_err = ERR_PARSE; n_cr = 1'b0;
                        end else begin
                            n_cnt = p + 16'd1;
                            if (n_phase == PH_STATUS) begin
                                case (n_sub)
                                    S_VER_OK, S_VER_BAD: begin
                                        if (cb.data == 8'h20)
                                            n_sub = (n_sub == S_VER_BAD || p < 16'd8)
                                                    ? S_BADVER : S_CODE0;
                                        else if (p < 16'd7 && cb.data != ver_char(p[2:0]))
                                            n_sub = S_VER_BAD;
                                    end
                                    S_CODE0, S_CODE: begin
                                        if (cb.is_digit) begin
                                            cv = 14'(n_code) * 14'd10 + 14'(cb.data[3:0]);
                                            n_code = (cv > 14'd600) ? 10'd600 : cv[9:0];
                                            n_sub = S_CODE;
                                        end else if (cb.data == 8'h20)
                                            n_sub = (n_sub == S_CODE) ? S_REASON : S_BAD;
                                        else n_sub = S_BAD;
                                    end
                                    default: ;
                                endcase
                            end else begin
                                case (n_sub)
                                    H_NAME: begin
                                        if (cb.data == 8'h3A) begin
                                            if (p == '0) n_sub = H_BAD;
                                            else begin
                                                logic [4:0] f;
                                                f = '0;
                                                if ((n_flags & F_CL) != '0 && p == 16'd14)
                                                    f = F_LCL;
                                                if ((n_flags & F_TE) != '0 && p == 16'd17)
                                                    f = F_LTE;
                                                n_flags = f; n_acc = '0;
                                                n_sub = (f != '0) ? H_LEAD : H_SKIP;
                                            end
                                        end else begin
                                            if (p >= 16'd14 || cb.lower != cl_char(p[3:0]))
                                                n_flags = n_flags & ~F_CL;
                                            if (p >= 16'd17 || cb.lower != te_char_at(p[4:0]))
                                                n_flags = n_flags & ~F_TE;
                                        end
                                    end
                                    H_LEAD, H_TE: begin
                                        if (n_sub == H_TE && cb.is_ws)
                                            n_sub = (n_acc == LB'(7)) ? H_TE_TAIL : H_SKIP;
                                        else if (n_sub == H_LEAD && cb.is_ws) ;
                                        else if (n_sub == H_TE || (n_flags & F_LTE) != '0) begin
                                            if (n_acc < LB'(7)
                                                && cb.lower == ck_char(n_acc[2:0])) begin
                                                n_acc = n_acc + 1'b1; n_sub = H_TE;
                                            end else n_sub = H_SKIP;
                                        end else if (cb.is_digit) begin
                                            n_acc = LB'(cb.data[3:0]); n_sub = H_CL;
                                        end else n_sub = H_SKIP;
                                    end
                                    H_CL: begin
                                        if (cb.is_digit) begin
                                            wv = WB'(n_acc) * WB'(10) + WB'(cb.data[3:0]);
                                            if (wv[WB-1:LB] != '0) n_sub = H_SKIP;
                                            else n_acc = wv[LB-1:0];
                                        end else n_sub = cb.is_ws ? H_CL_TAIL : H_SKIP;
                                    end
                                    H_CL_TAIL, H_TE_TAIL:
                                        if (!cb.is_ws) n_sub = H_SKIP;
                                    default: ;
                                endcase
                            end
                        end
                    end
                end
            end
        end
        if (n_phase == PH_CHUNKED && n_sub == 4'(CK_LEAD) && n_cnt == '0 && n_acc == '0
            && (n_flags & (F_CL | F_TE)) != '0)
            n_flags = '0;
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_obv <= bv;
            r_obd <= bv ? i_q_beat.data : 8'd0;
        end
        if (!i_rst_n) begin
            r_phase <= PH_STATUS; r_sub <= S_VER_OK; r_cnt <= '0; r_cr <= 1'b0;
            r_code <= '0; r_flags <= '0; r_acc <= '0; r_chk <= 1'b0; r_lseen <= 1'b0;
            r_rem <= '0; r_trail <= '0; r_err <= ERR_NONE; r_ov <= 1'b0;
        end else begin
            if (take) begin
                r_phase <= n_phase; r_sub <= n_sub; r_cnt <= n_cnt; r_cr <= n_cr;
                r_code <= n_code; r_flags <= n_flags; r_acc <= n_acc; r_chk <= n_chk;
                r_lseen <= n_lseen; r_rem <= n_rem; r_trail <= n_trail; r_err <= n_err;
            end
            if (take) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
        end
    end

    `HRSP_ASSERT(a_err_sticky, i_clk, i_rst_n, (r_phase == PH_ERROR) |=> (r_phase == PH_ERROR), "error phase left")
    `HRSP_ASSERT(a_done_sticky, i_clk, i_rst_n, (r_phase == PH_DONE) |=> (r_phase == PH_DONE), "complete phase left")
    `HRSP_ASSERT(a_body_phase, i_clk, i_rst_n, (r_ov && r_obv) |-> (r_phase != PH_STATUS && r_phase != PH_HEADERS), "body byte in header phase")
    `HRSP_ASSERT(a_hold, i_clk, i_rst_n, (r_ov && i_stall) |=> $stable(r_phase), "result changed while stalled")
endmodule

FILE: hw/rtl/http_response_stream_parser.sv
// HTTP/1.x response stream parser, one byte per beat.
// Input channel i_valid/o_stall carries i_in_byte; output channel
// o_valid/i_stall carries one result per input beat: o_body_valid,
// o_body_data, o_phase, o_resp_code, o_error_kind.
// Config channel i_cfg_valid/o_cfg_ready writes max_line_bytes (index 0)
// or max_chunk_bytes (index 1); other indexes are ignored.
// A byte passes through a two-entry queue and then the parse stage, which
// registers its result in the output register.
// Throughput is one byte per cycle while the receiver does not stall.
// When the receiver stalls the result holds, the queue fills, and
// o_stall rises once both queue entries are taken.
// Reset (synchronous, active low) returns to the status line phase and
// restores the configuration defaults.
// Depends on hrsp_pkg, hrsp_front and hrsp_back.
module http_response_stream_parser
    import hrsp_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_body_valid,
    output logic [7:0]  o_body_data,
    output logic [2:0]  o_phase,
    output logic [9:0]  o_resp_code,
    output logic [2:0]  o_error_kind,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    logic [15:0] r_max_line;
    logic [31:0] r_max_chunk;
    logic        q_valid, q_pop;
    t_beat       q_beat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_line  <= MAX_LINE_RESET;
            r_max_chunk <= MAX_CHUNK_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAX_LINE:  r_max_line  <= i_cfg_data[15:0];
                CFG_MAX_CHUNK: r_max_chunk <= i_cfg_data;
                default: ;
            endcase
        end
    end

    hrsp_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_in_byte,
        .o_q_valid(q_valid), .o_q_beat(q_beat), .i_q_pop(q_pop)
    );

    hrsp_back #(.LENGTH_BITS(LENGTH_BITS)) u_back (
        .i_clk, .i_rst_n,
        .i_q_valid(q_valid), .i_q_beat(q_beat), .o_q_pop(q_pop),
        .i_max_line(r_max_line), .i_max_chunk(r_max_chunk),
        .o_valid, .i_stall, .o_body_valid, .o_body_data,
        .o_phase, .o_resp_code, .o_error_kind
    );
endmodule

FILE: bench/testbench.sv
// Self-checking bench for the HTTP response stream parser: drives one response
// byte stream and checks every result beat against a built-in parser model.
// Depends on hrsp_pkg and http_response_stream_parser.
module testbench;
    import hrsp_pkg::*;

    localparam int             RUN_LIMIT = 300000;
    localparam longint unsigned LMASK    = 64'hFFFF_FFFF;

    // header match flags
    localparam int FL_CAND_CL = 1;
    localparam int FL_CAND_TE = 2;
    localparam int FL_LINE_CL = 4;
    localparam int FL_LINE_TE = 8;
    localparam int FL_OVER    = 16;

    localparam string VER_WORD = "HTTP/1.";
    localparam string CL_WORD  = "content-length";
    localparam string TE_WORD  = "transfer-encoding";
    localparam string CK_WORD  = "chunked";
    localparam string FIRST_LINE = "HTTP/1.1 200 OK\r\n";

    typedef struct {
        bit         body_valid;
        logic [7:0] body_data;
        logic [2:0] phase;
        logic [9:0] resp_code;
        logic [2:0] error_kind;
    } parse_res_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_in_byte;
    logic        o_valid;
    logic        i_stall;
    logic        o_body_valid;
    logic [7:0]  o_body_data;
    logic [2:0]  o_phase;
    logic [9:0]  o_resp_code;
    logic [2:0]  o_error_kind;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    http_response_stream_parser u_top (.*);

    // parser model state
    logic [15:0]     lim_line;
    logic [31:0]     lim_chunk;
    logic [2:0]      ph;
    t_sub            lsub;
    t_csub           csub;
    logic [15:0]     line_cnt;
    bit              cr_pend;
    int unsigned     code_acc;
    int              flags;
    longint unsigned len_acc;
    bit              chunked_seen;
    bit              length_seen;
    longint unsigned remain;
    int              trail_cnt;
    logic [2:0]      err_kind;

    parse_res_t expected_q[$];
    int         mismatches;
    int         bytes_sent;
    int         idle_pct;
    int         stall_pct;
    int         hold_req;
    int         hold_left;
    int         cycles;

    function automatic int lower_of(int c);
        return (c >= "A" && c <= "Z") ? c + 32 : c;
    endfunction

    function automatic int hex_of(int c);
        int l;
        l = lower_of(c);
        if (c >= "0" && c <= "9") return c - "0";
        if (l >= "a" && l <= "f") return l - "a" + 10;
        return -1;
    endfunction

    function automatic bit is_blank(int c);
        return c == " " || c == "\t";
    endfunction

    function void parse_fail(logic [2:0] kind);
        if (ph == PH_STATUS) code_acc = 0;
        ph       = PH_ERROR;
        err_kind = kind;
        cr_pend  = 0;
    endfunction

    function void new_line();
        lsub     = (ph == PH_STATUS) ? S_VER_OK : H_NAME;
        csub     = CK_LEAD;
        line_cnt = 0;
        len_acc  = 0;
        flags    = FL_CAND_CL | FL_CAND_TE;
    endfunction

    function void status_char(int c, int p);
        case (lsub)
            S_VER_OK, S_VER_BAD: begin
                if (c == " ")
                    lsub = (lsub == S_VER_BAD || p < 8) ? S_BADVER : S_CODE0;
                else if (p < 7 && c != VER_WORD[p])
                    lsub = S_VER_BAD;
            end
            S_CODE0, S_CODE: begin
                if (c >= "0" && c <= "9") begin
                    code_acc = code_acc * 10 + (c - "0");
                    if (code_acc > 600) code_acc = 600;
                    lsub = S_CODE;
                end else if (c == " ") begin
                    lsub = (lsub == S_CODE) ? S_REASON : S_BAD;
                end else begin
                    lsub = S_BAD;
                end
            end
            default: ;
        endcase
    endfunction

    function void chunked_char(int c);
        if (len_acc < 7 && lower_of(c) == CK_WORD[len_acc]) begin
            len_acc = len_acc + 1;
            lsub    = H_TE;
        end else begin
            lsub = H_SKIP;
        end
    endfunction

    function void header_char(int c, int p);
        int f;
        int l;
        longint unsigned d;
        case (lsub)
            H_NAME: begin
                if (c == ":") begin
                    f = 0;
                    if (p == 0) begin
                        lsub = H_BAD;
                    end else begin
                        if ((flags & FL_CAND_CL) && p == 14) f = FL_LINE_CL;
                        if ((flags & FL_CAND_TE) && p == 17) f = FL_LINE_TE;
                        flags   = f;
                        len_acc = 0;
                        lsub    = (f != 0) ? H_LEAD : H_SKIP;
                    end
                end else begin
                    l = lower_of(c);
                    if (p >= 14 || l != CL_WORD[p]) flags &= ~FL_CAND_CL;
                    if (p >= 17 || l != TE_WORD[p]) flags &= ~FL_CAND_TE;
                end
            end
            H_LEAD: begin
                if (!is_blank(c)) begin
                    if (flags & FL_LINE_TE) begin
                        chunked_char(c);
                    end else if (c >= "0" && c <= "9") begin
                        len_acc = c - "0";
                        lsub    = H_CL;
                    end else begin
                        lsub = H_SKIP;
                    end
                end
            end
            H_CL: begin
                if (c >= "0" && c <= "9") begin
                    d = c - "0";
                    if (len_acc > (LMASK - d) / 10) lsub = H_SKIP;
                    else len_acc = len_acc * 10 + d;
                end else begin
                    lsub = is_blank(c) ? H_CL_TAIL : H_SKIP;
                end
            end
            H_CL_TAIL, H_TE_TAIL: begin
                if (!is_blank(c)) lsub = H_SKIP;
            end
            H_TE: begin
                if (is_blank(c)) lsub = (len_acc == 7) ? H_TE_TAIL : H_SKIP;
                else chunked_char(c);
            end
            default: ;
        endcase
    endfunction

    function void size_char(int c);
        int h;
        longint unsigned v;
        h = hex_of(c);
        case (csub)
            CK_LEAD: begin
                if (c != " ") begin
                    csub = (h < 0) ? CK_BAD : CK_HEX;
                    if (h >= 0) begin
                        len_acc = h;
                        if (len_acc > lim_chunk) flags |= FL_OVER;
                    end
                end
            end
            CK_HEX: begin
                if (h < 0) begin
                    csub = CK_REST;
                end else if (!(flags & FL_OVER)) begin
                    v = len_acc * 16 + h;
                    if (v > lim_chunk || v > LMASK) flags |= FL_OVER;
                    else len_acc = v;
                end
            end
            default: ;
        endcase
    endfunction

    function void line_char(int c);
        int p;
        p = line_cnt;
        if (ph == PH_CHUNKED) begin
            size_char(c);
        end else if (p >= lim_line) begin
            parse_fail(ERR_PARSE);
        end else begin
            line_cnt = p + 1;
            if (ph == PH_STATUS) status_char(c, p);
            else header_char(c, p);
        end
    endfunction

    function void line_done();
        if (ph == PH_STATUS) begin
            if (lsub == S_BADVER) begin
                parse_fail(ERR_VERSION);
                return;
            end
            if ((lsub != S_CODE && lsub != S_REASON) || code_acc < 100 || code_acc > 599) begin
                parse_fail(ERR_PARSE);
                return;
            end
            ph = PH_HEADERS;
        end else if (ph == PH_HEADERS) begin
            if (lsub == H_NAME && line_cnt == 0) begin
                if (chunked_seen) ph = PH_CHUNKED;
                else if (length_seen) ph = (remain != 0) ? PH_FIXED : PH_DONE;
                else ph = PH_EOF;
            end else if (lsub == H_NAME || lsub == H_BAD) begin
                parse_fail(ERR_HEADER);
                return;
            end else if (lsub == H_CL || lsub == H_CL_TAIL) begin
                remain      = len_acc;
                length_seen = 1;
            end else if ((lsub == H_TE && len_acc == 7) || lsub == H_TE_TAIL) begin
                chunked_seen = 1;
            end
        end else begin
            if (csub == CK_LEAD || csub == CK_BAD || (flags & FL_OVER)) begin
                parse_fail(ERR_CHUNK);
                return;
            end
            if (len_acc == 0) begin
                ph = PH_DONE;
                return;
            end
            remain = len_acc;
            csub   = CK_DATA;
            return;
        end
        new_line();
    endfunction

    function void line_byte(int c);
        if (cr_pend) begin
            cr_pend = 0;
            if (c == "\n") begin
                line_done();
                return;
            end
            line_char("\r");
            if (ph == PH_ERROR) return;
        end
        if (c == "\r") cr_pend = 1;
        else line_char(c);
    endfunction

    function void parser_reset();
        lim_line     = MAX_LINE_RESET;
        lim_chunk    = MAX_CHUNK_RESET;
        ph           = PH_STATUS;
        cr_pend      = 0;
        code_acc     = 0;
        chunked_seen = 0;
        length_seen  = 0;
        remain       = 0;
        trail_cnt    = 0;
        err_kind     = ERR_NONE;
        new_line();
        flags        = 0;
    endfunction

    function parse_res_t parse_byte(logic [7:0] b);
        parse_res_t r;
        int c;
        c = b;
        r.body_valid = 0;
        r.body_data  = 0;
        case (ph)
            PH_STATUS, PH_HEADERS: line_byte(c);
            PH_CHUNKED: begin
                if (csub == CK_DATA) begin
                    r.body_valid = 1;
                    r.body_data  = b;
                    remain = (remain - 1) & LMASK;
                    if (remain == 0) begin
                        csub      = CK_TRAIL;
                        trail_cnt = 2;
                    end
                end else if (csub == CK_TRAIL) begin
                    if (trail_cnt == 2 && c == "\r") begin
                        trail_cnt = 1;
                    end else if (trail_cnt == 1 && c == "\n") begin
                        trail_cnt = 0;
                        new_line();
                        flags = 0;
                    end else begin
                        trail_cnt = 0;
                        parse_fail(ERR_CHUNK);
                    end
                end else begin
                    line_byte(c);
                end
            end
            PH_FIXED: begin
                r.body_valid = 1;
                r.body_data  = b;
                remain = (remain - 1) & LMASK;
                if (remain == 0) ph = PH_DONE;
            end
            PH_EOF: begin
                r.body_valid = 1;
                r.body_data  = b;
            end
            default: ;
        endcase
        if (ph == PH_CHUNKED && csub == CK_LEAD && line_cnt == 0 && len_acc == 0
                && (flags & (FL_CAND_CL | FL_CAND_TE)))
            flags = 0;
        r.phase       = ph;
        r.resp_code   = (ph == PH_STATUS) ? 10'd0 : code_acc[9:0];
        r.error_kind  = (ph == PH_ERROR) ? err_kind : ERR_NONE;
        return r;
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("[http_response_stream_parser] ERROR");
            $finish;
        end
    end

    // receiver: random stall, or one long hold-off when asked
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                i_stall <= 1'b1;
            end else if (hold_req != 0) begin
                hold_req  = 0;
                hold_left = 80;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // compare every accepted result beat with the oldest expectation
    always @(posedge i_clk) begin
        parse_res_t e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_q.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected result beat: phase %0d", o_phase);
            end else begin
                e = expected_q.pop_front();
                if (o_body_valid !== e.body_valid || o_body_data !== e.body_data
                        || o_phase !== e.phase || o_resp_code !== e.resp_code
                        || o_error_kind !== e.error_kind) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display({"mismatch: exp bv %0d bd %02h ph %0d code %0d err %0d,",
                                  " got bv %0d bd %02h ph %0d code %0d err %0d"},
                                 e.body_valid, e.body_data, e.phase, e.resp_code,
                                 e.error_kind, o_body_valid, o_body_data, o_phase,
                                 o_resp_code, o_error_kind);
                end
            end
        end
    end

    task automatic send_byte(logic [7:0] b, bit typed, parse_res_t typed_res);
        parse_res_t r;
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        do @(posedge i_clk); while (o_stall);
        r = parse_byte(b);
        expected_q.push_back(typed ? typed_res : r);
        bytes_sent = bytes_sent + 1;
        case ((bytes_sent / 250) % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 87; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 87; end
            default: begin idle_pct = 37; stall_pct = 37; end
        endcase
        if (bytes_sent == 1050) hold_req = 1;
        @(negedge i_clk);
    endtask

    task automatic send_text(string s);
        parse_res_t none;
        none = '{default: 0};
        foreach (s[k]) send_byte(s[k], 1'b0, none);
    endtask

    // drain to idle, then write one register
    task automatic write_reg(logic [0:0] idx, logic [31:0] val);
        i_valid <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (4) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_MAX_LINE) lim_line = val[15:0];
        else lim_chunk = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_chunk();
        int unsigned cap;
        int unsigned n;
        string hx;
        parse_res_t none;
        none = '{default: 0};
        cap = (lim_chunk < 40) ? lim_chunk : 40;
        n   = $urandom_range(cap, 1);
        hx  = $sformatf("%0h", n);
        if ($urandom_range(1)) hx = hx.toupper();
        repeat ($urandom_range(2)) send_text(" ");
        if ($urandom_range(3) == 0) send_text("0");
        send_text(hx);
        case ($urandom_range(5))
            0: send_text(";ext=val");
            1: send_text(" ;a\rb");
            default: ;
        endcase
        send_text("\r\n");
        repeat (n) send_byte($urandom_range(255), 1'b0, none);
        send_text("\r\n");
    endtask

    initial begin
        parse_res_t row;
        int unsigned lim_steps[4];
        int step_ix;
        lim_steps = '{32'hFFFF_FFFF, 1, 7, MAX_CHUNK_RESET};
        step_ix     = 0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_in_byte   = 8'h00;
        i_stall     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_MAX_LINE;
        i_cfg_data  = 32'h0;
        mismatches  = 0;
        bytes_sent  = 0;
        idle_pct    = 0;
        stall_pct   = 0;
        hold_req    = 0;
        hold_left   = 0;
        cycles      = 0;
        parser_reset();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        write_reg(CFG_MAX_LINE, 32'd65535);
        // status line: every beat stays in the status phase until the final LF
        foreach (FIRST_LINE[k]) begin
            row = '{0, 8'h00, PH_STATUS, 10'd0, ERR_NONE};
            if (k == FIRST_LINE.len() - 1) begin
                row.phase     = PH_HEADERS;
                row.resp_code = 10'd200;
            end
            send_byte(FIRST_LINE[k], 1'b1, row);
        end

        write_reg(CFG_MAX_LINE, 32'd30);
        send_text("Content-Length: 4294967295\r\n");
        send_text("content-LENGTH: 4294967296\r\n");
        send_text("X-Y: z\r\n");
        send_text("Transfer-Encoding:  cHunked \r\n");
        send_text("\r\n");
        write_reg(CFG_MAX_LINE, 32'd1);

        while (bytes_sent < 1400) begin
            if (bytes_sent / 300 != step_ix / 1 && step_ix < 4) begin
                write_reg(CFG_MAX_CHUNK, lim_steps[step_ix]);
                step_ix = step_ix + 1;
            end
            send_chunk();
        end

        write_reg(CFG_MAX_CHUNK, 32'd0);
        send_text("0\r\n");
        send_text("\r\nXYZ");
        i_valid <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("[http_response_stream_parser] OK");
        else
            $display("[http_response_stream_parser] ERROR");
        $finish;
    end
endmodule

FILE: http_response_stream_parser.f
+incdir+hw/rtl
hw/rtl/hrsp_pkg.sv
hw/rtl/hrsp_front.sv
hw/rtl/hrsp_back.sv
hw/rtl/http_response_stream_parser.sv
bench/testbench.sv
